@@ hw/rtl/iprf_pkg.sv @@
// Types, constants and a helper function shared by the IPv4 prefix rule filter.
package iprf_pkg;

	// Widths of the item fields.
	localparam int unsigned PFX_W = 32;
	localparam int unsigned LEN_W = 6;
	localparam int unsigned IDX_OUT_W = 8;

	// Longest prefix length that can ever match.
	localparam logic [LEN_W-1:0] PLEN_LIMIT = 6'd32;

	// Operation codes carried in tuser.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_APPLY = 1'b1;

	// Rule type codes.
	localparam logic TYPE_STRICT = 1'b0;
	localparam logic TYPE_LOOSE = 1'b1;

	// One stored rule, 40 bits, prefix in the low bits.
	typedef struct packed {
		logic rule_action;
		logic rule_type;
		logic [LEN_W-1:0] length;
		logic [PFX_W-1:0] prefix;
	} rule_t;

	// One result item, 11 bits, verdict in the low bit.
	typedef struct packed {
		logic error;
		logic [IDX_OUT_W-1:0] rule_index;
		logic hit;
		logic verdict;
	} result_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	// Mask of the top len bits of a prefix; len is at most 32 where used.
	function automatic logic [PFX_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [PFX_W-1:0] m;
		m = '0;
		for (int i = 0; i < PFX_W; i++) begin
			m[PFX_W-1-i] = (LEN_W'(i) < len);
		end
		return m;
	endfunction

endpackage

@@ hw/rtl/ipv4_prefix_rule_filter.sv @@
// IPv4 prefix rule filter: rule table in a synchronous memory, scanned newest to oldest.
// An apply checks rules from the newest down to and including the first match
// (all stored rules when none matches, none for an empty table or a query length above 32).
// A new item is taken once the previous result sits in the output register.
// arst_n clears the rule count, default action, sequencer and output valid; table contents
// are not cleared and entries at or above the count are never read.
module ipv4_prefix_rule_filter #(
	parameter int unsigned MAX_RULES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: default_action register.
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // prefix[31:0], length[37:32], rule_type[38], rule_action[39]
	input  logic        s_tuser,   // op
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // verdict[0], hit[1], rule_index[9:2], error[10], zero fill
);

	import iprf_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
	localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

	// Rule memory, one write and one registered read per cycle.
	rule_t rule_mem [MAX_RULES];
	rule_t rd_data_q;

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic default_action_q;
	logic [PFX_W-1:0] q_prefix_q;
	logic [LEN_W-1:0] q_len_q;
	logic [IDX_W-1:0] chk_idx_q;
	result_t res_q;
	logic m_tvalid_q;
	result_t m_data_q;

	// Input decode.
	rule_t in_rule;
	logic s_acc;
	logic is_append;
	logic app_err;
	logic [CNT_W-1:0] cnt_m1;

	// Control from the sequencer.
	logic mem_we;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic load_query;
	logic step_idx;
	logic res_load;
	result_t res_d;
	logic out_load;

	// Match of the entry read last cycle against the query.
	logic [PFX_W-1:0] mask;
	logic rule_match;

	assign in_rule = rule_t'(s_tdata);
	assign s_acc = s_tvalid && s_tready;
	assign is_append = (s_tuser == OP_APPEND);
	assign app_err = (count_q >= CNT_W'(MAX_RULES)) || (in_rule.length > PLEN_LIMIT);
	assign cnt_m1 = count_q - CNT_W'(1);

	assign mask = len_mask(rd_data_q.length);

	always_comb begin
		if (rd_data_q.rule_type == TYPE_STRICT) begin
			rule_match = (rd_data_q.prefix == q_prefix_q) && (rd_data_q.length == q_len_q);
		end else begin
			rule_match = (rd_data_q.length <= PLEN_LIMIT) && (q_len_q >= rd_data_q.length)
				&& ((rd_data_q.prefix & mask) == (q_prefix_q & mask));
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		mem_we = 1'b0;
		rd_en = 1'b0;
		rd_addr = chk_idx_q;
		load_query = 1'b0;
		step_idx = 1'b0;
		res_load = 1'b0;
		res_d = '0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_acc) begin
					res_load = 1'b1;
					if (is_append) begin
						res_d.error = app_err;
						mem_we = !app_err;
						state_d = ST_RESP;
					end else if ((count_q == '0) || (in_rule.length > PLEN_LIMIT)) begin
						res_d.verdict = default_action_q;
						state_d = ST_RESP;
					end else begin
						// Start the scan at the newest rule.
						load_query = 1'b1;
						rd_en = 1'b1;
						rd_addr = cnt_m1[IDX_W-1:0];
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (rule_match) begin
					res_load = 1'b1;
					res_d.verdict = rd_data_q.rule_action;
					res_d.hit = 1'b1;
					res_d.rule_index = IDX_OUT_W'(chk_idx_q);
					state_d = ST_RESP;
				end else if (chk_idx_q == '0) begin
					res_load = 1'b1;
					res_d.verdict = default_action_q;
					state_d = ST_RESP;
				end else begin
					// Move on to the next older rule.
					rd_en = 1'b1;
					rd_addr = chk_idx_q - IDX_W'(1);
					step_idx = 1'b1;
				end
			end
			ST_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Rule memory write and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			rule_mem[count_q[IDX_W-1:0]] <= in_rule;
		end
		if (rd_en) begin
			rd_data_q <= rule_mem[rd_addr];
		end
	end

	// Rule count and default action register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			default_action_q <= 1'b0;
		end else begin
			if (mem_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cfg_wr_en) begin
				default_action_q <= cfg_wr_data;
			end
		end
	end

	// Query, scan index and pending result.
	always_ff @(posedge clk) begin
		if (load_query) begin
			q_prefix_q <= in_rule.prefix;
			q_len_q <= in_rule.length;
			chk_idx_q <= cnt_m1[IDX_W-1:0];
		end else if (step_idx) begin
			chk_idx_q <= chk_idx_q - IDX_W'(1);
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			m_data_q <= res_q;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {5'b0, m_data_q};

	// The rule count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RULES))
		else $error("rule count above table size");

	// The scan only looks at stored rules.
	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, chk_idx_q} < {1'b0, count_q}))
		else $error("scan index outside stored rules");

	// A refused append leaves the table size unchanged.
	a_refused_append: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && is_append && app_err) |=> $stable(count_q))
		else $error("refused append changed the rule count");

	// An accepted append that is not refused grows the table by one.
	a_stored_append: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && is_append && !app_err) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("stored append did not grow the rule count");

	// A new result appears only from the response state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_RESP))
		else $error("result raised outside the response state");

endmodule
